>>> rtl/spcsg_pkg.sv
package spcsg_pkg;

  localparam int POS_W  = 24;
  localparam int TIME_W = 32;
  localparam int DUR_W  = 30;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] REG_XLEN   = 3'd0;
  localparam logic [2:0] REG_YLEN   = 3'd1;
  localparam logic [2:0] REG_XTIME  = 3'd2;
  localparam logic [2:0] REG_YTIME  = 3'd3;
  localparam logic [2:0] REG_DELAY  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_us;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] x_pos;
    logic signed [23:0] y_pos;
    logic [3:0]         phase_now;
    logic               running;
    logic               done_pulse;
    logic               finished;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LEG_X,
    ST_LEG_Y,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_MUL,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

>>> rtl/square_path_cubic_setpoint_generator_unit.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid/in_ready    | spcsg_pkg::in_req_t (func, now_us)
// out_     | output    | out_valid/out_ready  | spcsg_pkg::out_req_t
// cfg_     | input     | APB psel/penable     | five setting registers at 4*i
// One request is taken at a time. Each axis that a tick marches runs one setup step,
// 32 restoring divide steps, three multiply steps, one rounding step and one wrap-up.
// A tick moving both axes marches x, then y. An axis whose leg has already ended goes from
// setup straight to wrap-up; other requests go from dispatch straight to wrap-up.
// rst_n is synchronous and active low; settings return to their defaults.
// The result waits in the output register until taken, and the next request can be accepted
// in the cycle after that.
module square_path_cubic_setpoint_generator_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spcsg_pkg::in_req_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spcsg_pkg::out_req_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [22:0] xlen_r, ylen_r;
  logic [29:0] xtime_r, ytime_r, delay_r;

  spcsg_pkg::state_t state_r, state_nxt;

  logic [1:0]  func_r;
  logic [31:0] now_r;
  logic [3:0]  phase_r;
  logic        en_r, fin_r, done_r;
  logic [31:0] hold_r;
  logic signed [23:0] xo_r, yo_r;
  logic signed [23:0] xf_r, xt_r, yf_r, yt_r;
  logic [29:0] xus_r, yus_r;
  logic [31:0] xst_r, yst_r;
  logic        xs_r, ys_r;
  logic        xend_r, yend_r;
  logic        axis_r;
  logic        march_r;

  // shared arithmetic registers
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [4:0]  cnt_r;
  logic [31:0] s2_r;
  logic [32:0] f_r;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [24:0] ad_r;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [23:0] hx, hy;
  assign hx = $signed({2'b00, xlen_r[22:1]});
  assign hy = $signed({2'b00, ylen_r[22:1]});

  assign cfg_pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[4:2])
      spcsg_pkg::REG_XLEN:  cfg_prdata = {9'd0, xlen_r};
      spcsg_pkg::REG_YLEN:  cfg_prdata = {9'd0, ylen_r};
      spcsg_pkg::REG_XTIME: cfg_prdata = {2'd0, xtime_r};
      spcsg_pkg::REG_YTIME: cfg_prdata = {2'd0, ytime_r};
      spcsg_pkg::REG_DELAY: cfg_prdata = {2'd0, delay_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlen_r  <= 23'd65536;
      ylen_r  <= 23'd65536;
      xtime_r <= 30'd1000000;
      ytime_r <= 30'd1000000;
      delay_r <= 30'd1000000;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        spcsg_pkg::REG_XLEN:  xlen_r  <= cfg_pwdata[22:0];
        spcsg_pkg::REG_YLEN:  ylen_r  <= cfg_pwdata[22:0];
        spcsg_pkg::REG_XTIME: xtime_r <= cfg_pwdata[29:0];
        spcsg_pkg::REG_YTIME: ytime_r <= cfg_pwdata[29:0];
        spcsg_pkg::REG_DELAY: delay_r <= cfg_pwdata[29:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ready  = (state_r == spcsg_pkg::ST_IDLE);
    out_valid = (state_r == spcsg_pkg::ST_OUT);
  end
  assign out_data  = '{x_pos: xo_r, y_pos: yo_r, phase_now: phase_r, running: en_r,
                       done_pulse: done_r, finished: fin_r};

  // current leg of the axis being marched
  logic [29:0] dur;
  logic [31:0] st_eff, el;
  logic        leg_end;
  logic signed [23:0] lf, lt;
  always_comb begin
    dur    = axis_r ? yus_r : xus_r;
    st_eff = axis_r ? (ys_r ? yst_r : now_r) : (xs_r ? xst_r : now_r);
    lf     = axis_r ? yf_r : xf_r;
    lt     = axis_r ? yt_r : xt_r;
    el     = now_r - st_eff;
    leg_end = (el >= {2'd0, dur});
  end

  logic hold_over;
  assign hold_over = ((now_r - hold_r) > {2'd0, delay_r});

  // one restoring divide step; the remainder stays below the duration
  logic [31:0] rem_sh;
  logic [32:0] trial;
  always_comb begin
    rem_sh = {rem_r[30:0], 1'b0};
    trial  = {1'b0, rem_sh} - {3'd0, dur};
  end

  logic signed [25:0] d_full;
  assign d_full = 26'(lt) - 26'(lf);

  always_comb begin
    mul_a = 33'd0;
    mul_b = 33'd0;
    case (state_r)
      spcsg_pkg::ST_SQ:   begin mul_a = {1'b0, quo_r}; mul_b = {1'b0, quo_r}; end
      spcsg_pkg::ST_CUBE: begin mul_a = {1'b0, s2_r};  mul_b = {1'b0, quo_r}; end
      spcsg_pkg::ST_MUL:  begin mul_a = {8'd0, ad_r};  mul_b = f_r; end
      default: ;
    endcase
  end

  logic marchx, marchy, tick_live;
  always_comb begin
    marchx = (phase_r == 4'd1) || (phase_r == 4'd11) || (phase_r == 4'd3) ||
             (phase_r == 4'd7);
    marchy = (phase_r == 4'd1) || (phase_r == 4'd11) || (phase_r == 4'd5) ||
             (phase_r == 4'd9);
    tick_live = (func_r == spcsg_pkg::FUNC_TICK) && en_r && !fin_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spcsg_pkg::ST_IDLE:     if (in_valid) state_nxt = spcsg_pkg::ST_DISPATCH;
      spcsg_pkg::ST_DISPATCH: begin
        if (tick_live && marchx)      state_nxt = spcsg_pkg::ST_LEG_X;
        else if (tick_live && marchy) state_nxt = spcsg_pkg::ST_LEG_Y;
        else                          state_nxt = spcsg_pkg::ST_FINISH;
      end
      spcsg_pkg::ST_LEG_X, spcsg_pkg::ST_LEG_Y:
        state_nxt = leg_end ? spcsg_pkg::ST_FINISH : spcsg_pkg::ST_DIV;
      spcsg_pkg::ST_DIV:      if (cnt_r == 5'd31) state_nxt = spcsg_pkg::ST_SQ;
      spcsg_pkg::ST_SQ:       state_nxt = spcsg_pkg::ST_CUBE;
      spcsg_pkg::ST_CUBE:     state_nxt = spcsg_pkg::ST_MUL;
      spcsg_pkg::ST_MUL:      state_nxt = spcsg_pkg::ST_ROUND;
      spcsg_pkg::ST_ROUND:    state_nxt = spcsg_pkg::ST_FINISH;
      spcsg_pkg::ST_FINISH: begin
        if (march_r && !axis_r && marchy) state_nxt = spcsg_pkg::ST_LEG_Y;
        else                              state_nxt = spcsg_pkg::ST_OUT;
      end
      spcsg_pkg::ST_OUT:      if (out_ready) state_nxt = spcsg_pkg::ST_IDLE;
      default:                state_nxt = spcsg_pkg::ST_IDLE;
    endcase
  end

  logic [33:0] fcalc;
  logic [32:0] fclamp;
  logic [63:0] rnd;
  logic [24:0] mag;
  logic signed [25:0] rsum;
  logic signed [23:0] rsat;
  always_comb begin
    // 3*s^2 - 2*s^3, clamped to one
    fcalc  = {2'd0, s2_r} + {1'b0, s2_r, 1'b0} - {1'b0, mul_p[63:32], 1'b0};
    fclamp = (fcalc > 34'h1_0000_0000) ? 33'h1_0000_0000 : fcalc[32:0];
    rnd   = prod_r + 64'h8000_0000;
    mag   = rnd[56:32];
    rsum  = neg_r ? 26'(lf) - 26'(mag) : 26'(lf) + 26'(mag);
    if (rsum > 26'sd8388607)       rsat = 24'sh7FFFFF;
    else if (rsum < -26'sd8388608) rsat = 24'sh800000;
    else                           rsat = rsum[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcsg_pkg::ST_IDLE;
      phase_r <= 4'd0; en_r <= 1'b0; fin_r <= 1'b0; done_r <= 1'b0;
      hold_r <= 32'd0; xo_r <= '0; yo_r <= '0;
      xf_r <= '0; xt_r <= '0; yf_r <= '0; yt_r <= '0;
      xus_r <= '0; yus_r <= '0; xst_r <= '0; yst_r <= '0;
      xs_r <= 1'b0; ys_r <= 1'b0; xend_r <= 1'b0; yend_r <= 1'b0; axis_r <= 1'b0;
      march_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        spcsg_pkg::ST_IDLE: if (in_valid) begin
          func_r <= in_data.func;
          now_r  <= in_data.now_us;
          done_r <= 1'b0;
        end
        spcsg_pkg::ST_DISPATCH: begin
          march_r <= tick_live && (marchx || marchy);
          case (func_r)
            spcsg_pkg::FUNC_TICK: if (en_r && !fin_r) begin
              xend_r <= 1'b1; yend_r <= 1'b1;
              axis_r <= !marchx;
              case (phase_r)
                4'd0: begin
                  xf_r <= '0; xt_r <= hx; xus_r <= {1'b0, xtime_r[29:1]}; xs_r <= 1'b0;
                  yf_r <= '0; yt_r <= hy; yus_r <= {1'b0, ytime_r[29:1]}; ys_r <= 1'b0;
                  xo_r <= '0; yo_r <= '0; phase_r <= 4'd1;
                end
                4'd2: if (hold_over) begin
                  xf_r <= hx; xt_r <= -hx; xus_r <= xtime_r; xs_r <= 1'b0; phase_r <= 4'd3;
                end else begin xo_r <= hx; yo_r <= hy; end
                4'd4: if (hold_over) begin
                  yf_r <= hy; yt_r <= -hy; yus_r <= ytime_r; ys_r <= 1'b0; phase_r <= 4'd5;
                end else begin xo_r <= -hx; yo_r <= hy; end
                4'd6: if (hold_over) begin
                  xf_r <= -hx; xt_r <= hx; xus_r <= xtime_r; xs_r <= 1'b0; phase_r <= 4'd7;
                end else begin xo_r <= -hx; yo_r <= -hy; end
                4'd8: if (hold_over) begin
                  yf_r <= -hy; yt_r <= hy; yus_r <= ytime_r; ys_r <= 1'b0; phase_r <= 4'd9;
                end else begin xo_r <= hx; yo_r <= -hy; end
                4'd10: if (hold_over) begin
                  yf_r <= yo_r; yt_r <= '0; yus_r <= {1'b0, ytime_r[29:1]}; ys_r <= 1'b0;
                  xf_r <= xo_r; xt_r <= '0; xus_r <= {1'b0, xtime_r[29:1]}; xs_r <= 1'b0;
                  phase_r <= 4'd11;
                end
                4'd12: if (hold_over) begin
                  fin_r <= 1'b1; en_r <= 1'b0; done_r <= 1'b1;
                end else begin xo_r <= '0; yo_r <= '0; end
                4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: ;
                default: en_r <= 1'b0;
              endcase
            end
            spcsg_pkg::FUNC_START: begin
              if (fin_r) en_r <= 1'b0;
              else begin
                phase_r <= 4'd0; en_r <= 1'b1; hold_r <= now_r;
                xo_r <= '0; yo_r <= '0;
              end
            end
            spcsg_pkg::FUNC_CLEAR: begin
              en_r <= 1'b0; fin_r <= 1'b0; phase_r <= 4'd0;
              xo_r <= '0; yo_r <= '0;
            end
            default: ;
          endcase
        end
        spcsg_pkg::ST_LEG_X, spcsg_pkg::ST_LEG_Y: begin
          if (axis_r) begin
            if (!ys_r) begin yst_r <= now_r; ys_r <= 1'b1; end
            yend_r <= leg_end;
          end else begin
            if (!xs_r) begin xst_r <= now_r; xs_r <= 1'b1; end
            xend_r <= leg_end;
          end
          rem_r <= el;
          quo_r <= 32'd0;
          cnt_r <= 5'd0;
          neg_r <= d_full[25];
          ad_r  <= d_full[25] ? 25'(-d_full) : d_full[24:0];
        end
        spcsg_pkg::ST_DIV: begin
          // quotient of el*2^32/dur, one bit a cycle
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
        end
        spcsg_pkg::ST_SQ: begin
          s2_r <= mul_p[63:32];
        end
        spcsg_pkg::ST_CUBE: begin
          f_r <= fclamp;
        end
        spcsg_pkg::ST_MUL: begin
          prod_r <= mul_p[63:0];
        end
        spcsg_pkg::ST_ROUND: begin
          if (axis_r) yo_r <= rsat; else xo_r <= rsat;
        end
        spcsg_pkg::ST_FINISH: begin
          // phase advance once every marched leg has ended
          if (march_r) begin
            if (!axis_r && marchy) begin
              axis_r <= 1'b1;
            end else if (xend_r && yend_r) begin
              phase_r <= phase_r + 4'd1;
              hold_r  <= now_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
